FILE: rtl/string_literal_escaper_macros.svh
// assertion macros used by the escaper back end
// expects clk and rst_n in the scope of each use
`ifndef STRING_LITERAL_ESCAPER_MACROS_SVH
`define STRING_LITERAL_ESCAPER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sle_pkg.sv
// shared types, character codes and lead-byte decode for the escaper
// no dependencies
`timescale 1ns / 1ps

package sle_pkg;

  // item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // multibyte modes
  localparam logic MODE_SJIS = 1'b0;
  localparam logic MODE_UTF8 = 1'b1;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // lead-byte ranges
  localparam logic [7:0] SJIS_A_LO = 8'h81;
  localparam logic [7:0] SJIS_A_HI = 8'h9f;
  localparam logic [7:0] SJIS_B_LO = 8'he0;
  localparam logic [7:0] SJIS_B_HI = 8'hfc;
  localparam logic [7:0] UTF_1_LO  = 8'hc2;
  localparam logic [7:0] UTF_1_HI  = 8'hdf;
  localparam logic [7:0] UTF_2_LO  = 8'he0;
  localparam logic [7:0] UTF_2_HI  = 8'hef;
  localparam logic [7:0] UTF_3_LO  = 8'hf0;
  localparam logic [7:0] UTF_3_HI  = 8'hf7;
  localparam logic [7:0] UTF_4_LO  = 8'hf8;
  localparam logic [7:0] UTF_4_HI  = 8'hfb;
  localparam logic [7:0] UTF_5_LO  = 8'hfc;
  localparam logic [7:0] UTF_5_HI  = 8'hfd;

  // plan queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one classified item: up to four output bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic            done;
  } sle_plan_t;

  // number of trail bytes that follow a lead byte
  function automatic logic [2:0] trail_count(input logic [7:0] c, input logic mode);
    logic [2:0] res;
    res = 3'd0;
    if (mode == MODE_SJIS) begin
      if ((c >= SJIS_A_LO && c <= SJIS_A_HI) || (c >= SJIS_B_LO && c <= SJIS_B_HI))
        res = 3'd1;
    end else begin
      if (c >= UTF_1_LO && c <= UTF_1_HI)      res = 3'd1;
      else if (c >= UTF_2_LO && c <= UTF_2_HI) res = 3'd2;
      else if (c >= UTF_3_LO && c <= UTF_3_HI) res = 3'd3;
      else if (c >= UTF_4_LO && c <= UTF_4_HI) res = 3'd4;
      else if (c >= UTF_5_LO && c <= UTF_5_HI) res = 3'd5;
    end
    return res;
  endfunction

endpackage

FILE: rtl/sle_front.sv
// front end: accepts items, tracks string state, builds byte plans
// depends on sle_pkg
`timescale 1ns / 1ps

module sle_front import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_mode,
  input  logic      accept,
  input  logic      kind,
  input  logic [7:0] data_byte,
  output logic      plan_push,
  output sle_plan_t plan
);

  logic       mode_r;
  logic       in_string_r, in_string_nxt;
  logic       cr_pending_r, cr_pending_nxt;
  logic [2:0] trail_r, trail_nxt;
  logic [2:0] n_c;
  logic       handled_c;

  // classify the item and lay out its output bytes
  always_comb begin
    plan           = '0;
    n_c            = 3'd0;
    handled_c      = 1'b0;
    in_string_nxt  = in_string_r;
    cr_pending_nxt = cr_pending_r;
    trail_nxt      = trail_r;

    if (!in_string_r) begin
      plan.bytes[n_c[1:0]] = CH_QUOTE;
      n_c = n_c + 3'd1;
      in_string_nxt = 1'b1;
    end

    if (kind == KIND_END) begin
      if (cr_pending_r) begin
        plan.bytes[n_c[1:0]] = CH_BSLASH;
        n_c = n_c + 3'd1;
        plan.bytes[n_c[1:0]] = CH_R;
        n_c = n_c + 3'd1;
      end
      plan.bytes[n_c[1:0]] = CH_QUOTE;
      n_c = n_c + 3'd1;
      plan.done      = 1'b1;
      in_string_nxt  = 1'b0;
      cr_pending_nxt = 1'b0;
      trail_nxt      = 3'd0;
    end else if (trail_r != 3'd0) begin
      plan.bytes[n_c[1:0]] = data_byte;
      n_c = n_c + 3'd1;
      trail_nxt = trail_r - 3'd1;
    end else begin
      // a held carriage return resolves first
      if (cr_pending_r) begin
        cr_pending_nxt = 1'b0;
        plan.bytes[n_c[1:0]] = CH_BSLASH;
        n_c = n_c + 3'd1;
        if (data_byte == CH_LF) begin
          plan.bytes[n_c[1:0]] = CH_N;
          n_c = n_c + 3'd1;
          handled_c = 1'b1;
        end else begin
          plan.bytes[n_c[1:0]] = CH_R;
          n_c = n_c + 3'd1;
        end
      end
      if (!handled_c) begin
        unique case (data_byte)
          CH_TAB: begin
            plan.bytes[n_c[1:0]] = CH_BSLASH;
            n_c = n_c + 3'd1;
            plan.bytes[n_c[1:0]] = CH_T;
            n_c = n_c + 3'd1;
          end
          CH_QUOTE: begin
            plan.bytes[n_c[1:0]] = CH_BSLASH;
            n_c = n_c + 3'd1;
            plan.bytes[n_c[1:0]] = CH_QUOTE;
            n_c = n_c + 3'd1;
          end
          CH_BSLASH: begin
            plan.bytes[n_c[1:0]] = CH_BSLASH;
            n_c = n_c + 3'd1;
            plan.bytes[n_c[1:0]] = CH_BSLASH;
            n_c = n_c + 3'd1;
          end
          CH_CR: begin
            cr_pending_nxt = 1'b1;
          end
          default: begin
            plan.bytes[n_c[1:0]] = data_byte;
            n_c = n_c + 3'd1;
            trail_nxt = trail_count(data_byte, mode_r);
          end
        endcase
      end
    end

    plan.cnt_m1 = 2'(n_c - 3'd1);
  end

  // only items that produce bytes enter the queue
  assign plan_push = accept && (n_c != 3'd0);

  // string state and mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SJIS;
      in_string_r  <= 1'b0;
      cr_pending_r <= 1'b0;
      trail_r      <= 3'd0;
    end else begin
      if (cfg_we)
        mode_r <= cfg_mode;
      if (accept) begin
        in_string_r  <= in_string_nxt;
        cr_pending_r <= cr_pending_nxt;
        trail_r      <= trail_nxt;
      end
    end
  end

endmodule

FILE: rtl/sle_queue.sv
// short plan queue between front and back end
// depends on sle_pkg
`timescale 1ns / 1ps

module sle_queue import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sle_plan_t wdata,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output sle_plan_t rdata
);

  sle_plan_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];
  assign wr_en = push && !full;
  assign rd_en = pop && valid;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en)
      mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en)
        wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en)
        rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !rd_en)
        count_r <= count_r + 1'b1;
      else if (rd_en && !wr_en)
        count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: rtl/sle_back.sv
// back end: walks each plan and presents one byte per transfer
// depends on sle_pkg and string_literal_escaper_macros.svh
`timescale 1ns / 1ps
`include "string_literal_escaper_macros.svh"

module sle_back import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  sle_plan_t q_data,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output logic [7:0] out_byte,
  output logic      out_last,
  output logic      out_string_done
);

  sle_plan_t  cur_r;
  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic       at_last;
  logic       pop_fire;
  logic       load;

  assign at_last  = (idx_r == cur_r.cnt_m1);
  assign pop_fire = out_pop && valid_r;
  assign load     = q_valid && (!valid_r || (pop_fire && at_last));
  assign q_pop    = load;

  // result ports
  assign out_empty       = !valid_r;
  assign out_byte        = cur_r.bytes[idx_r];
  assign out_last        = at_last;
  assign out_string_done = cur_r.done && at_last;

  // byte index and holding register control
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (pop_fire) begin
      if (at_last)
        valid_nxt = 1'b0;
      else
        idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load)
      cur_r <= q_data;
  end

  // checks
  `SLE_ASSERT_HOLDS(a_idx_in_plan, valid_r, idx_r <= cur_r.cnt_m1, "byte index past plan end")
  `SLE_ASSERT_NEXT(a_stall_holds, valid_r && !out_pop, valid_r && $stable(idx_r), "stall moved index")
  `SLE_ASSERT_NEXT(a_drain_empties, pop_fire && at_last && !q_valid, !valid_r, "drained but not empty")
  `SLE_ASSERT_NEXT(a_idle_loads, !valid_r && q_valid, valid_r && idx_r == 2'd0, "plan not loaded")

endmodule

FILE: rtl/string_literal_escaper.sv
// Quoted string literal escaper: input queue port, result queue port, mode register.
// Input: push an item (kind, data_byte) whenever full is low; a string is its bytes
// followed by one end item. Results: while out_empty is low, out_byte, out_last and
// out_string_done show the oldest byte; pop takes it. out_last marks the final byte
// of one item, out_string_done the closing quote.
// The first byte of an item passes the plan queue write and then the back end holding
// register before it is visible; a carriage return item that only holds its decision
// gives no result.
// Throughput: one item per cycle while each item yields one byte and out_pop stays
// high; an item that yields n bytes holds the result port for n pops. Four classified
// items can wait in the plan queue, after which full rises until the receiver pops.
// A stalled receiver holds the current byte; nothing is lost or repeated.
// Config: cfg_ready is always high; change the mode only while the block is idle.
// Reset (rst_n low, synchronous) clears string state, the queue and the mode
// (Shift-JIS); the block accepts items in the first cycle after reset.
// Depends on sle_pkg, sle_front, sle_queue and sle_back.
`timescale 1ns / 1ps

module string_literal_escaper import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_string_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_multibyte_mode
);

  logic      accept;
  logic      plan_push;
  sle_plan_t plan;
  logic      q_valid;
  logic      q_pop;
  sle_plan_t q_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  // classify items
  sle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_mode  (cfg_multibyte_mode),
    .accept    (accept),
    .kind      (in_kind),
    .data_byte (in_data_byte),
    .plan_push (plan_push),
    .plan      (plan)
  );

  // decoupling queue
  sle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (plan_push),
    .wdata (plan),
    .full  (in_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_data)
  );

  // emit bytes
  sle_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_string_done (out_string_done)
  );

endmodule

FILE: tb/sv/string_literal_escaper_tb.sv
// testbench for string_literal_escaper: queued strings against a built-in escape predictor
// depends on sle_pkg and the string_literal_escaper rtl
`timescale 1ns / 1ps

module string_literal_escaper_tb;
  import sle_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 38;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } lit_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_kind = KIND_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_string_done;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_multibyte_mode = MODE_SJIS;

  // items waiting to be offered, bytes of the literal still owed by the block
  text_item_t text_backlog[$];
  lit_byte_t  literal_due[$];

  // predictor state
  logic       esc_mode = MODE_SJIS;
  logic       open_lit = 1'b0;
  logic       cr_held = 1'b0;
  logic [2:0] trail_left = 3'd0;
  lit_byte_t  step_out[4];
  int         step_n;

  // handshake bookkeeping
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   phase_items = 0;

  string_literal_escaper u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_kind            (in_kind),
    .in_data_byte       (in_data_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_string_done    (out_string_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_multibyte_mode (cfg_multibyte_mode)
  );

  always #10 clk = ~clk;

  // trail bytes that follow a lead byte under the given mode
  function automatic logic [2:0] run_length(input logic [7:0] c, input logic m);
    if (m == MODE_SJIS)
      return ((c >= SJIS_A_LO && c <= SJIS_A_HI) || (c >= SJIS_B_LO && c <= SJIS_B_HI)) ?
             3'd1 : 3'd0;
    casez (c)
      8'b1100_000?: return 3'd0;
      8'b110?_????: return 3'd1;
      8'b1110_????: return 3'd2;
      8'b1111_0???: return 3'd3;
      8'b1111_10??: return 3'd4;
      8'b1111_110?: return 3'd5;
      default:      return 3'd0;
    endcase
  endfunction

  // idle length between transfers: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches = mismatches + 1;
    if (mismatches <= 100)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
  endtask

  task put_char(input logic [7:0] ch, input logic done);
    step_out[step_n] = '{ch: ch, last: 1'b0, done: done};
    step_n = step_n + 1;
  endtask

  // escape one accepted item and append its bytes to the owed list
  task automatic escape_item(input logic kind, input logic [7:0] c);
    logic crlf;
    crlf = 1'b0;
    step_n = 0;
    if (!open_lit) begin
      put_char(CH_QUOTE, 1'b0);
      open_lit = 1'b1;
    end
    if (kind == KIND_END) begin
      if (cr_held) begin
        put_char(CH_BSLASH, 1'b0);
        put_char(CH_R, 1'b0);
      end
      put_char(CH_QUOTE, 1'b1);
      open_lit = 1'b0;
      cr_held = 1'b0;
      trail_left = 3'd0;
    end else if (trail_left != 3'd0) begin
      // trail bytes pass through untouched
      put_char(c, 1'b0);
      trail_left = trail_left - 3'd1;
    end else begin
      // a held carriage return resolves to \n or \r
      if (cr_held) begin
        cr_held = 1'b0;
        crlf = (c == CH_LF);
        put_char(CH_BSLASH, 1'b0);
        put_char(crlf ? CH_N : CH_R, 1'b0);
      end
      if (!crlf) begin
        case (c)
          CH_TAB: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_T, 1'b0);
          end
          CH_QUOTE: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_QUOTE, 1'b0);
          end
          CH_BSLASH: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_BSLASH, 1'b0);
          end
          CH_CR: cr_held = 1'b1;
          default: begin
            put_char(c, 1'b0);
            trail_left = run_length(c, esc_mode);
          end
        endcase
      end
    end
    if (step_n > 0) step_out[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) literal_due.push_back(step_out[i]);
  endtask

  task automatic add_item(input logic kind, input logic [7:0] data);
    text_item_t it;
    it.kind = kind;
    it.data = data;
    text_backlog.push_back(it);
    phase_items = phase_items + 1;
  endtask

  // mostly escapes and multibyte runs with random content, the rest raw bytes
  task automatic add_random_string(input logic closed, input int max_tokens);
    int         tokens;
    int         runs;
    logic [7:0] lead;
    logic       cut;
    tokens = $urandom_range(0, max_tokens);
    cut = 1'b0;
    for (int t = 0; t < tokens && !cut; t++) begin
      case ($urandom_range(0, 9))
        0: add_item(KIND_BYTE, CH_TAB);
        1: add_item(KIND_BYTE, CH_QUOTE);
        2: add_item(KIND_BYTE, CH_BSLASH);
        3: add_item(KIND_BYTE, CH_CR);
        4: begin
          add_item(KIND_BYTE, CH_CR);
          add_item(KIND_BYTE, CH_LF);
        end
        5: add_item(KIND_BYTE, CH_LF);
        6, 7: begin
          if (esc_mode == MODE_SJIS)
            lead = $urandom_range(0, 1) ? 8'($urandom_range(SJIS_A_LO, SJIS_A_HI)) :
                                          8'($urandom_range(SJIS_B_LO, SJIS_B_HI));
          else
            lead = 8'($urandom_range(UTF_1_LO, UTF_5_HI));
          runs = int'(run_length(lead, esc_mode));
          // now and then the run is cut short by the end of the string
          if ($urandom_range(0, 7) == 0) begin
            runs = int'($urandom_range(0, runs));
            cut = 1'b1;
          end
          add_item(KIND_BYTE, lead);
          for (int k = 0; k < runs; k++) add_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
        default: add_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      endcase
    end
    if (closed) add_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // called at a falling edge while the block is idle
  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_multibyte_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    esc_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // everything offered and returned, then a wait for items with no output
  task automatic wait_drained();
    do @(negedge clk); while (text_backlog.size() != 0 || in_push || literal_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // sender: one offer stands until its transfer
  always @(negedge clk) begin
    text_item_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && !in_took) begin
      // keep offering
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_push <= 1'b0;
    end else if (text_backlog.size() > 0) begin
      nxt = text_backlog.pop_front();
      in_push <= 1'b1;
      in_kind <= nxt.kind;
      in_data_byte <= nxt.data;
      send_gap = steady ? 0 : pick_gap();
    end else begin
      in_push <= 1'b0;
    end
  end

  // receiver: random gaps, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_pop <= 1'b0;
    end else begin
      if (out_took && !steady) recv_gap = pick_gap();
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // check each result transfer, then predict from each input transfer
  always @(posedge clk) begin
    lit_byte_t want;
    in_took <= rst_n && in_push && !in_full;
    out_took <= rst_n && out_pop && !out_empty;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (literal_due.size() == 0) begin
          note_mismatch("no byte expected", int'(out_byte), -1);
        end else begin
          want = literal_due.pop_front();
          if (out_byte !== want.ch)
            note_mismatch("out_byte", int'(out_byte), int'(want.ch));
          if (out_last !== want.last)
            note_mismatch("out_last", int'(out_last), int'(want.last));
          if (out_string_done !== want.done)
            note_mismatch("out_string_done", int'(out_string_done), int'(want.done));
        end
        results_seen = results_seen + 1;
      end
      if (in_push && !in_full) escape_item(in_kind, in_data_byte);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** string_literal_escaper: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // shift-jis: empty string, escapes, crlf, lone cr, lead runs, cut run
    write_mode(MODE_SJIS);
    steady = 1'b1;
    add_item(KIND_END, 8'hff);
    add_item(KIND_BYTE, CH_TAB);
    add_item(KIND_BYTE, CH_QUOTE);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, 8'h00);
    add_item(KIND_BYTE, 8'hff);
    add_item(KIND_BYTE, CH_CR);
    add_item(KIND_BYTE, CH_LF);
    add_item(KIND_BYTE, CH_CR);
    add_item(KIND_BYTE, SJIS_A_LO);
    add_item(KIND_BYTE, CH_QUOTE);
    add_item(KIND_BYTE, SJIS_B_LO);
    add_item(KIND_END, 8'h00);
    add_item(KIND_BYTE, CH_CR);
    add_item(KIND_END, 8'h00);
    wait_drained();

    // utf-8: five-byte run cut short, then a run left open across a mode change
    write_mode(MODE_UTF8);
    add_item(KIND_BYTE, UTF_5_HI);
    add_item(KIND_BYTE, CH_CR);
    add_item(KIND_END, 8'h00);
    add_item(KIND_BYTE, UTF_3_LO);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, CH_TAB);
    wait_drained();

    write_mode(MODE_SJIS);
    add_item(KIND_BYTE, CH_CR);
    add_item(KIND_BYTE, SJIS_A_LO);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_END, 8'h00);
    wait_drained();

    // random strings, alternating modes; a phase may end inside a string
    for (int p = 0; p < 5; p++) begin
      write_mode(p[0] ? MODE_SJIS : MODE_UTF8);
      steady = (p == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) add_random_string(1'b1, 10);
      if ($urandom_range(0, 1)) add_random_string(1'b0, 3);
      if (p == 1) hold_req = 1'b1;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("** string_literal_escaper: PASSED **");
    end else begin
      $display("** string_literal_escaper: FAILED **");
    end
    $finish;
  end

endmodule
